[hdl/sli_pkg.sv]
// Shared types and constants for the ordered list block.
// No dependencies; every other source file takes names from here by scope or by import.
package sli_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 6;
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted item
    logic exec;   // carry out the held item and load the result register
  } ctrl_cmd_t;

endpackage

[hdl/sli_if.sv]
// Valid/ready channel interfaces for operation items and result items.
// Depends on sli_pkg for field widths.
interface sli_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic [sli_pkg::POS_W-1:0]           position;
  logic signed [sli_pkg::VAL_W-1:0]    value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface sli_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [sli_pkg::CNT_W-1:0]           count;
  logic signed [sli_pkg::VAL_W-1:0]    read_value;

  modport source (output valid, output status, output count, output read_value, input ready);
  modport sink   (input valid, input status, input count, input read_value, output ready);
endinterface

[hdl/sli_ctrl.sv]
// Sequencer for the ordered list: accepts one item, runs it, hands the result on.
// Depends on sli_pkg for the command struct.
module sli_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sli_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   exec_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // result register is free when empty or being drained this cycle
  assign exec_ok   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = exec_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_ok) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (exec_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[hdl/sli_dpath.sv]
// Datapath for the ordered list: held item, row of shifting cells, count
// and result register. Depends on sli_pkg for types and widths.
module sli_dpath #(
  parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sli_pkg::ctrl_cmd_t                cmd,
  input  logic [1:0]                        in_func,
  input  logic [sli_pkg::POS_W-1:0]         in_position,
  input  logic signed [sli_pkg::VAL_W-1:0]  in_value,
  output logic [1:0]                        out_status,
  output logic [sli_pkg::CNT_W-1:0]         out_count,
  output logic signed [sli_pkg::VAL_W-1:0]  out_read_value
);

  localparam int CW = sli_pkg::CNT_W;
  localparam int PW = sli_pkg::POS_W;
  localparam int VW = sli_pkg::VAL_W;
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // held item
  sli_pkg::op_t          op_r;
  logic [PW-1:0]         pos_r;
  logic signed [VW-1:0]  val_r;

  logic signed [VW-1:0]  cell_r   [DEPTH];
  logic signed [VW-1:0]  cell_nxt [DEPTH];
  logic signed [VW-1:0]  up_nb    [DEPTH];
  logic signed [VW-1:0]  dn_nb    [DEPTH];
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;

  logic [1:0]            status_r;
  logic [CW-1:0]         count_r;
  logic signed [VW-1:0]  read_r;

  logic [1:0]            status_c;
  logic signed [VW-1:0]  read_c;
  logic [PW-1:0]         pidx;
  logic                  full;
  logic                  pos_ok_ins;
  logic                  pos_ok_rm;
  logic                  do_app;
  logic                  do_ins;
  logic                  do_rm;

  // neighbours for the shift in either direction
  for (genvar i = 0; i < DEPTH; i++) begin : g_nb
    if (i == 0) begin : g_first
      assign up_nb[i] = val_r;
    end else begin : g_up
      assign up_nb[i] = cell_r[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign dn_nb[i] = cell_r[i];
    end else begin : g_dn
      assign dn_nb[i] = cell_r[i+1];
    end
  end

  assign pidx       = pos_r - PW'(1);
  assign full       = (cnt_r == FULL_CNT);
  assign pos_ok_ins = (pos_r != '0) && ({1'b0, pos_r} <= ({1'b0, cnt_r} + (CW+1)'(1)));
  assign pos_ok_rm  = (pos_r != '0) && (pos_r <= cnt_r);

  always_comb begin
    status_c = sli_pkg::ST_DONE;
    read_c   = '0;
    do_app   = 1'b0;
    do_ins   = 1'b0;
    do_rm    = 1'b0;
    case (op_r)
      sli_pkg::OP_APPEND: begin
        if (full) status_c = sli_pkg::ST_FULL;
        else      do_app   = 1'b1;
      end
      sli_pkg::OP_INSERT: begin
        if (!pos_ok_ins) status_c = sli_pkg::ST_RANGE;
        else if (full)   status_c = sli_pkg::ST_FULL;
        else             do_ins   = 1'b1;
      end
      sli_pkg::OP_REMOVE: begin
        if (!pos_ok_rm) status_c = sli_pkg::ST_RANGE;
        else            do_rm    = 1'b1;
      end
      sli_pkg::OP_READ: begin
        if (!pos_ok_rm) status_c = sli_pkg::ST_RANGE;
        else            read_c   = cell_r[pidx[IW-1:0]];
      end
      default: status_c = sli_pkg::ST_DONE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_app && (CW'(i) == cnt_r)) begin
        cell_nxt[i] = val_r;
      end else if (do_ins && (PW'(i) == pidx)) begin
        cell_nxt[i] = val_r;
      end else if (do_ins && (PW'(i) > pidx)) begin
        cell_nxt[i] = up_nb[i];
      end else if (do_rm && (PW'(i) >= pidx)) begin
        cell_nxt[i] = dn_nb[i];
      end
    end
    cnt_nxt = cnt_r;
    if (do_app || do_ins) cnt_nxt = cnt_r + CW'(1);
    else if (do_rm)       cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= sli_pkg::op_t'(in_func);
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) cell_r[i] <= cell_nxt[i];
      status_r <= status_c;
      count_r  <= cnt_nxt;
      read_r   <= read_c;
    end
  end

  assign out_status     = status_r;
  assign out_count      = count_r;
  assign out_read_value = read_r;

endmodule

[hdl/sequential_list_insert_remove.sv]
// Ordered list of up to DEPTH signed values: append, insert, remove, read.
// An accepted item is captured into the held-item registers, then executed into the
// result register once that is free. The controller holds one item at a time, and the
// result register lets the next item in while a result waits.
// Reset: synchronous active-low rst_n clears the count and the handshake state;
// the list cells are not cleared, since only entries below the count are read.
module sequential_list_insert_remove #(
  parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sli_in_if.sink     in_ch,
  sli_out_if.source  out_ch
);

  sli_pkg::ctrl_cmd_t cmd;

  // Controller: owns the input ready, the result valid and the sequencing.
  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: held item, shifting cells, element count and result register.
  sli_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_func        (in_ch.func),
    .in_position    (in_ch.position),
    .in_value       (in_ch.value),
    .out_status     (out_ch.status),
    .out_count      (out_ch.count),
    .out_read_value (out_ch.read_value)
  );

  // Only one item is in work: after an accept, hold off the next one.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item accepted while one is in work");

  // With the result register empty, an accepted item's result follows with no stall.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !out_ch.valid) |=> ##1 out_ch.valid)
    else $error("result did not follow accepted item");

  // A full status only ever comes with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == sli_pkg::ST_FULL)) |-> (out_ch.count == DEPTH))
    else $error("full status with list not full");

  // The count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.count <= DEPTH))
    else $error("count above depth");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the ordered list block: append, insert, remove, read.
// Depends on sli_pkg, the sli_in_if/sli_out_if interfaces and the block itself.
module tb_top;
  import sli_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    status_t            status;
    logic [CNT_W-1:0]   count;
    logic signed [31:0] read_value;
  } list_result_t;

  logic clk;
  logic rst_n;

  sli_in_if  in_ch ();
  sli_out_if out_ch ();

  sequential_list_insert_remove dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the list, entry 0 is position 1
  logic signed [31:0] list_shadow[$];
  // Results still owed by the block, oldest first
  list_result_t       owed_results[$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  bit  steady_flow    = 0;   // when set, neither side idles

  // Clock: period 10
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow list and work out the result it gives.
  // Range checks come before the full check, as the block does.
  function automatic list_result_t apply_to_list(op_t op, logic [POS_W-1:0] pos,
                                                 logic signed [31:0] val);
    list_result_t r;
    int held;
    int p;
    held = list_shadow.size();
    p = int'(pos);
    r.status = ST_DONE;
    r.read_value = '0;
    case (op)
      OP_APPEND: begin
        if (held >= LIST_DEPTH) r.status = ST_FULL;
        else list_shadow.push_back(val);
      end
      OP_INSERT: begin
        if (p < 1 || p > held + 1) r.status = ST_RANGE;
        else if (held >= LIST_DEPTH) r.status = ST_FULL;
        else list_shadow.insert(p - 1, val);
      end
      OP_REMOVE: begin
        if (p < 1 || p > held) r.status = ST_RANGE;
        else list_shadow.delete(p - 1);
      end
      default: begin
        if (p < 1 || p > held) r.status = ST_RANGE;
        else r.read_value = list_shadow[p - 1];
      end
    endcase
    r.count = CNT_W'(list_shadow.size());
    return r;
  endfunction

  // Idle length before an item: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one item: idle for a random gap, then hold valid until the block takes it.
  // Valid stays high after acceptance so back-to-back items need no new rising edge on it.
  task automatic send_item(op_t op, logic [POS_W-1:0] pos, logic signed [31:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= op;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk); while (!in_ch.ready);
    // accepted at this edge: predict at once so the result finds its expectation
    owed_results.push_back(apply_to_list(op, pos, val));
  endtask

  // Drop valid once the stimulus of a test has all gone in
  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every owed result has come back
  task automatic drain_results();
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Position mostly inside the range that the operation accepts, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position(op_t op);
    int held;
    held = list_shadow.size();
    if ($urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 63));
    case (op)
      OP_INSERT: return POS_W'($urandom_range(1, held + 1));
      default: begin
        if (held == 0) return POS_W'($urandom_range(0, 3));
        return POS_W'($urandom_range(1, held));
      end
    endcase
  endfunction

  // Edge cases on a short list: empty list rejects, both ends, value extremes,
  // position zero and position 63, one beyond the end for insert, read and remove
  task automatic test_edge_ops();
    send_item(OP_READ,   6'd1,  32'sd0);
    send_item(OP_READ,   6'd0,  32'sd0);
    send_item(OP_REMOVE, 6'd1,  32'sd0);
    send_item(OP_INSERT, 6'd0,  32'sd5);
    send_item(OP_INSERT, 6'd2,  32'sd5);
    send_item(OP_INSERT, 6'd1,  32'sh8000_0000);
    send_item(OP_APPEND, 6'd63, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 6'd3,  -32'sd1);
    send_item(OP_INSERT, 6'd2,  32'sh5555_AAAA);
    send_item(OP_INSERT, 6'd6,  32'sd9);
    send_item(OP_READ,   6'd1,  32'sd0);
    send_item(OP_READ,   6'd2,  32'sd0);
    send_item(OP_READ,   6'd4,  32'sd0);
    send_item(OP_READ,   6'd5,  32'sd0);
    send_item(OP_READ,   6'd63, 32'sd0);
    send_item(OP_REMOVE, 6'd5,  32'sd0);
    send_item(OP_REMOVE, 6'd2,  32'sd0);
    send_item(OP_REMOVE, 6'd3,  32'sd0);
    send_item(OP_READ,   6'd2,  32'sd0);
    send_item(OP_REMOVE, 6'd63, 32'sd0);
    send_item(OP_REMOVE, 6'd1,  32'sd0);
    send_item(OP_REMOVE, 6'd1,  32'sd0);
    send_item(OP_READ,   6'd1,  32'sd0);
    release_input();
    drain_results();
  endtask

  // Fill the list, then hit the rejections of append, insert and read on a full list, then empty it
  task automatic test_full_list();
    int k;
    for (k = 0; k < LIST_DEPTH; k++) send_item(OP_APPEND, 6'd0, $urandom);
    send_item(OP_APPEND, 6'd0,  32'sd1);
    send_item(OP_INSERT, 6'd1,  32'sd2);
    send_item(OP_INSERT, POS_W'(LIST_DEPTH + 1), 32'sd3);
    send_item(OP_INSERT, POS_W'(LIST_DEPTH + 2), 32'sd4);
    send_item(OP_INSERT, 6'd0,  32'sd5);
    send_item(OP_READ,   POS_W'(LIST_DEPTH), 32'sd0);
    send_item(OP_READ,   POS_W'(LIST_DEPTH + 1), 32'sd0);
    send_item(OP_REMOVE, POS_W'(LIST_DEPTH), 32'sd0);
    send_item(OP_INSERT, POS_W'(LIST_DEPTH), 32'sh8000_0000);
    send_item(OP_READ,   POS_W'(LIST_DEPTH), 32'sd0);
    // empty from the front so every entry shifts down many times
    for (k = 0; k < LIST_DEPTH; k++) send_item(OP_REMOVE, 6'd1, 32'sd0);
    send_item(OP_REMOVE, 6'd1,  32'sd0);
    release_input();
    drain_results();
  endtask

  // Random operations in rounds that alternately grow and shrink the list,
  // so it sweeps between empty and full; every fourth round runs without idling
  task automatic test_random_ops();
    int round;
    int k;
    int roll;
    op_t op;
    for (round = 0; round < RANDOM_ITEMS / 100; round++) begin
      steady_flow = (round % 4 == 3);
      for (k = 0; k < 100; k++) begin
        roll = $urandom_range(0, 99);
        if (round % 2 == 0) begin
          // grow: mostly appends and inserts
          if (roll < 35) op = OP_APPEND;
          else if (roll < 70) op = OP_INSERT;
          else if (roll < 82) op = OP_REMOVE;
          else op = OP_READ;
        end else begin
          // shrink: mostly removes, reads in between
          if (roll < 10) op = OP_APPEND;
          else if (roll < 22) op = OP_INSERT;
          else if (roll < 72) op = OP_REMOVE;
          else op = OP_READ;
        end
        send_item(op, (op == OP_APPEND) ? POS_W'($urandom) : pick_position(op),
                  pick_value());
      end
    end
    steady_flow = 0;
    release_input();
    drain_results();
  endtask

  // Result side back-pressure: ready held in runs, low runs mostly short
  initial begin
    int hold;
    bit level;
    hold = 0;
    level = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (steady_flow) begin
        level = 1'b1;
        hold = 0;
      end else if (hold == 0) begin
        level = ($urandom_range(0, 3) != 0);
        if (level) hold = $urandom_range(1, 12);
        else if ($urandom_range(0, 9) == 0) hold = $urandom_range(10, 45);
        else hold = $urandom_range(1, 3);
      end else begin
        hold--;
      end
      out_ch.ready <= level;
    end
  end

  // Check every accepted result against the oldest expectation
  initial begin
    list_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d count %0d read_value %0d",
                   $time, out_ch.status, out_ch.count, out_ch.read_value);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_ch.status);
            mismatch_count++;
          end
          if (out_ch.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count,
                     out_ch.count);
            mismatch_count++;
          end
          if (out_ch.read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                     out_ch.read_value);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: timeout, %0d results still owed", $time, owed_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= OP_APPEND;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_ops();
    test_full_list();
    test_random_ops();

    // let any late result show up before the verdict
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sli_pkg.sv
hdl/sli_if.sv
hdl/sli_ctrl.sv
hdl/sli_dpath.sv
hdl/sequential_list_insert_remove.sv
tb/sv/tb_top.sv
